// ----- rtl/lfs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_pkg: shared types and constants of the line follower steering block
// Move and heading codes, the command passed from the decision front to the
// phase sequencer, the register file layout and the fixed phase constants.
// ----------------------------------------------------------------------------
package lfs_pkg;

    localparam int DUTY_W    = 8;
    localparam int HOLD_W    = 10;
    localparam int CFG_IDX_W = 3;

    // Fixed phase values
    localparam logic [DUTY_W-1:0] FULL_DUTY     = 8'd255;
    localparam logic [DUTY_W-1:0] ZERO_DUTY     = 8'd0;
    localparam logic [HOLD_W-1:0] IDLE_PULSE_MS = 10'd10;
    localparam logic [HOLD_W-1:0] HOLD_MAX      = 10'd1023;

    // Previous samples after reset
    localparam int PREV_RESET = 4;

    // Command queue geometry
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DUTY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID_DUTY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DUTY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DUTY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KICK_MS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MS        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_EXTRA_MS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_MS       = 3'd7;

    // Register reset values
    localparam logic [DUTY_W-1:0] RST_FAST_DUTY     = 8'd240;
    localparam logic [DUTY_W-1:0] RST_MID_DUTY      = 8'd208;
    localparam logic [DUTY_W-1:0] RST_SLOW_DUTY     = 8'd112;
    localparam logic [DUTY_W-1:0] RST_IDLE_DUTY     = 8'd16;
    localparam logic [DUTY_W-1:0] RST_KICK_MS       = 8'd30;
    localparam logic [DUTY_W-1:0] RST_RUN_MS        = 8'd50;
    localparam logic [DUTY_W-1:0] RST_TURN_EXTRA_MS = 8'd20;
    localparam logic [DUTY_W-1:0] RST_REST_MS       = 8'd100;

    typedef enum logic [1:0] {
        MV_MID   = 2'd0,
        MV_SLOW  = 2'd1,
        MV_LEFT  = 2'd2,
        MV_RIGHT = 2'd3
    } t_move;

    typedef enum logic [1:0] {
        HD_STRAIGHT = 2'd0,
        HD_LEFT     = 2'd1,
        HD_RIGHT    = 2'd2
    } t_heading;

    // Phases of one move
    typedef enum logic [3:0] {
        PH_PULSE = 4'b0001,
        PH_KICK  = 4'b0010,
        PH_RUN   = 4'b0100,
        PH_REST  = 4'b1000
    } t_phase;

    typedef struct packed {
        t_move    mv;
        t_heading heading;
        logic     keep;
        logic     long_run;
    } t_cmd;

    typedef struct packed {
        logic [DUTY_W-1:0] fast_duty;
        logic [DUTY_W-1:0] mid_duty;
        logic [DUTY_W-1:0] slow_duty;
        logic [DUTY_W-1:0] idle_duty;
        logic [DUTY_W-1:0] kick_ms;
        logic [DUTY_W-1:0] run_ms;
        logic [DUTY_W-1:0] turn_extra_ms;
        logic [DUTY_W-1:0] rest_ms;
    } t_cfg;

    // Clamp a widened hold time to the output range
    function automatic logic [HOLD_W-1:0] sat_hold(input logic [HOLD_W:0] value);
        logic [HOLD_W-1:0] result;
        if (value > {1'b0, HOLD_MAX}) begin
            result = HOLD_MAX;
        end else begin
            result = value[HOLD_W-1:0];
        end
        return result;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/lfs_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_if: channel interfaces of the line follower steering block
// Sensor sample channel, motor phase channel and register write channel,
// each a valid/ready handshake with source and sink views.
// ----------------------------------------------------------------------------
interface lfs_sample_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] right_level;
    logic [SAMPLE_BITS-1:0] center_level;
    logic [SAMPLE_BITS-1:0] left_level;
    logic                   long_run;

    modport source (
        output valid, right_level, center_level, left_level, long_run,
        input  ready
    );
    modport sink (
        input  valid, right_level, center_level, left_level, long_run,
        output ready
    );
endinterface

interface lfs_phase_if;
    logic                          valid;
    logic                          ready;
    logic [lfs_pkg::DUTY_W-1:0]    left_duty;
    logic [lfs_pkg::DUTY_W-1:0]    right_duty;
    logic [lfs_pkg::HOLD_W-1:0]    hold_ms;
    logic [1:0]                    heading_out;
    logic                          last_phase;

    modport source (
        output valid, left_duty, right_duty, hold_ms, heading_out, last_phase,
        input  ready
    );
    modport sink (
        input  valid, left_duty, right_duty, hold_ms, heading_out, last_phase,
        output ready
    );
endinterface

interface lfs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lfs_pkg::CFG_IDX_W-1:0] index;
    logic [lfs_pkg::DUTY_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface
`default_nettype wire

// ----- rtl/lfs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_front: steering decision
// Accepts one sample set per cycle while the command queue has room, runs the
// priority chain against the previous samples and pushes the chosen move.
// ----------------------------------------------------------------------------
module lfs_front #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    lfs_sample_if.sink         i_sample,
    input  wire logic          i_q_full,
    output logic               o_push,
    output lfs_pkg::t_cmd      o_cmd
);

    logic [SAMPLE_BITS-1:0] r_prev_right, r_prev_center, r_prev_left;
    lfs_pkg::t_heading      r_heading;

    logic [SAMPLE_BITS-1:0] r, c, l;
    lfs_pkg::t_move         n_mv;
    lfs_pkg::t_heading      n_heading;
    logic                   n_keep;

    assign r = i_sample.right_level;
    assign c = i_sample.center_level;
    assign l = i_sample.left_level;

    assign i_sample.ready = !i_q_full;
    assign o_push         = i_sample.valid && !i_q_full;

    // Pick the move: first comparison that holds wins
    always_comb begin
        n_keep    = 1'b0;
        n_mv      = lfs_pkg::MV_SLOW;
        n_heading = r_heading;
        priority if (l > c && r > c) begin
            n_mv = lfs_pkg::MV_MID;   n_heading = lfs_pkg::HD_STRAIGHT;
        end else if (l > c && l > r) begin
            n_mv = lfs_pkg::MV_RIGHT; n_heading = lfs_pkg::HD_RIGHT;
        end else if (r > c && r > l) begin
            n_mv = lfs_pkg::MV_LEFT;  n_heading = lfs_pkg::HD_LEFT;
        end else if (l < c && l < r) begin
            n_mv = lfs_pkg::MV_LEFT;  n_heading = lfs_pkg::HD_LEFT;
        end else if (r < c && r < l) begin
            n_mv = lfs_pkg::MV_RIGHT; n_heading = lfs_pkg::HD_RIGHT;
        end else if (r < r_prev_right && r < l) begin
            n_mv = lfs_pkg::MV_RIGHT; n_heading = lfs_pkg::HD_RIGHT;
        end else if (l < r_prev_left && l < r) begin
            n_mv = lfs_pkg::MV_LEFT;  n_heading = lfs_pkg::HD_LEFT;
        end else if (c > r_prev_center && l > r) begin
            n_mv = lfs_pkg::MV_RIGHT; n_heading = lfs_pkg::HD_RIGHT;
        end else if (c > r_prev_center && r > l) begin
            n_mv = lfs_pkg::MV_LEFT;  n_heading = lfs_pkg::HD_LEFT;
        end else if (r < r_prev_right && r < c) begin
            n_mv = lfs_pkg::MV_RIGHT; n_heading = lfs_pkg::HD_RIGHT;
        end else if (l < r_prev_left && l < c) begin
            n_mv = lfs_pkg::MV_LEFT;  n_heading = lfs_pkg::HD_LEFT;
        end else if (c < r_prev_center && c < l) begin
            n_mv = lfs_pkg::MV_SLOW;  n_heading = lfs_pkg::HD_STRAIGHT;
        end else if (c < r_prev_center && c < r) begin
            n_mv = lfs_pkg::MV_SLOW;  n_heading = lfs_pkg::HD_STRAIGHT;
        end else begin
            // repeat the last heading; straight repeats as slow run
            n_keep = 1'b1;
            priority if (r_heading == lfs_pkg::HD_STRAIGHT) begin
                n_mv = lfs_pkg::MV_SLOW;
            end else if (r_heading == lfs_pkg::HD_RIGHT) begin
                n_mv = lfs_pkg::MV_RIGHT;
            end else begin
                n_mv = lfs_pkg::MV_LEFT;
            end
        end
    end

    assign o_cmd = '{mv: n_mv, heading: n_heading, keep: n_keep,
                     long_run: i_sample.long_run};

    // Advance the sample history on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_right  <= SAMPLE_BITS'(lfs_pkg::PREV_RESET);
            r_prev_center <= SAMPLE_BITS'(lfs_pkg::PREV_RESET);
            r_prev_left   <= SAMPLE_BITS'(lfs_pkg::PREV_RESET);
            r_heading     <= lfs_pkg::HD_STRAIGHT;
        end else if (o_push) begin
            r_prev_right  <= r;
            r_prev_center <= c;
            r_prev_left   <= l;
            r_heading     <= n_heading;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lfs_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_queue: command queue
// Short first-in first-out buffer of decided moves between the decision
// front and the phase sequencer.
// ----------------------------------------------------------------------------
module lfs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lfs_pkg::t_cmd  i_cmd,
    input  wire logic           i_pop,
    output lfs_pkg::t_cmd       o_cmd,
    output logic                o_full,
    output logic                o_empty
);

    lfs_pkg::t_cmd                 r_mem [lfs_pkg::Q_DEPTH];
    logic [lfs_pkg::Q_PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [lfs_pkg::Q_CNT_W-1:0]   r_count;

    localparam logic [lfs_pkg::Q_PTR_W-1:0] PTR_LAST = lfs_pkg::Q_PTR_W'(lfs_pkg::Q_DEPTH - 1);
    localparam logic [lfs_pkg::Q_CNT_W-1:0] CNT_FULL = lfs_pkg::Q_CNT_W'(lfs_pkg::Q_DEPTH);

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Move pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lfs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lfs_back: phase sequencer
// Walks the head move of the queue through its motor phases, one phase per
// cycle into the output register unless stalled; pops it after its rest phase.
// ----------------------------------------------------------------------------
module lfs_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire lfs_pkg::t_cfg  i_cfg,
    input  wire lfs_pkg::t_cmd  i_cmd,
    input  wire logic           i_q_empty,
    output logic                o_pop,
    lfs_phase_if.source         o_phase
);

    lfs_pkg::t_phase                r_phase;
    logic                           r_started;
    logic                           r_valid;
    logic [lfs_pkg::DUTY_W-1:0]     r_left_duty, r_right_duty;
    logic [lfs_pkg::HOLD_W-1:0]     r_hold;
    logic [1:0]                     r_heading;
    logic                           r_last;

    lfs_pkg::t_phase                cur_phase;
    lfs_pkg::t_phase                n_phase;
    logic                           load;
    logic [lfs_pkg::DUTY_W-1:0]     n_left_duty, n_right_duty;
    logic [lfs_pkg::HOLD_W:0]       n_hold_wide;
    logic [lfs_pkg::HOLD_W:0]       run_hold;
    logic                           is_turn;

    // First phase of a fresh move depends on whether it repeats the heading
    assign cur_phase = r_started ? r_phase
                     : (i_cmd.keep ? lfs_pkg::PH_PULSE : lfs_pkg::PH_KICK);
    assign load  = !i_q_empty && (!r_valid || o_phase.ready);
    assign o_pop = load && (cur_phase == lfs_pkg::PH_REST);

    assign is_turn  = (i_cmd.mv == lfs_pkg::MV_LEFT) || (i_cmd.mv == lfs_pkg::MV_RIGHT);
    assign run_hold = (i_cmd.long_run ? {2'b00, i_cfg.run_ms, 1'b0}
                                      : {3'b000, i_cfg.run_ms})
                    + (is_turn ? {3'b000, i_cfg.turn_extra_ms} : '0);

    // Build the phase payload
    always_comb begin
        n_left_duty  = lfs_pkg::ZERO_DUTY;
        n_right_duty = lfs_pkg::ZERO_DUTY;
        n_hold_wide  = '0;
        n_phase      = lfs_pkg::PH_KICK;
        unique case (cur_phase)
            lfs_pkg::PH_PULSE: begin
                n_left_duty  = i_cfg.idle_duty;
                n_right_duty = i_cfg.idle_duty;
                n_hold_wide  = {1'b0, lfs_pkg::IDLE_PULSE_MS};
                n_phase      = lfs_pkg::PH_KICK;
            end
            lfs_pkg::PH_KICK: begin
                n_left_duty  = (i_cmd.mv == lfs_pkg::MV_LEFT) ? lfs_pkg::ZERO_DUTY
                                                              : lfs_pkg::FULL_DUTY;
                n_right_duty = (i_cmd.mv == lfs_pkg::MV_RIGHT) ? lfs_pkg::ZERO_DUTY
                                                               : lfs_pkg::FULL_DUTY;
                n_hold_wide  = {3'b000, i_cfg.kick_ms};
                n_phase      = lfs_pkg::PH_RUN;
            end
            lfs_pkg::PH_RUN: begin
                unique case (i_cmd.mv)
                    lfs_pkg::MV_MID: begin
                        n_left_duty  = i_cfg.mid_duty;
                        n_right_duty = i_cfg.mid_duty;
                    end
                    lfs_pkg::MV_SLOW: begin
                        n_left_duty  = i_cfg.slow_duty;
                        n_right_duty = i_cfg.slow_duty;
                    end
                    lfs_pkg::MV_RIGHT: begin
                        n_left_duty  = i_cfg.fast_duty;
                    end
                    lfs_pkg::MV_LEFT: begin
                        n_right_duty = i_cfg.fast_duty;
                    end
                    default: begin
                        n_left_duty  = lfs_pkg::ZERO_DUTY;
                    end
                endcase
                n_hold_wide = run_hold;
                n_phase     = lfs_pkg::PH_REST;
            end
            lfs_pkg::PH_REST: begin
                n_hold_wide = {3'b000, i_cfg.rest_ms};
                n_phase     = lfs_pkg::PH_KICK;
            end
            default: begin
                n_phase = lfs_pkg::PH_KICK;
            end
        endcase
    end

    // Track position within the head move
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= lfs_pkg::PH_KICK;
            r_started <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (load) begin
                r_phase   <= n_phase;
                r_started <= (cur_phase != lfs_pkg::PH_REST);
                r_valid   <= 1'b1;
            end else if (o_phase.ready) begin
                r_valid   <= 1'b0;
            end
        end
    end

    // Hold the output item until taken
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_left_duty  <= n_left_duty;
            r_right_duty <= n_right_duty;
            r_hold       <= lfs_pkg::sat_hold(n_hold_wide);
            r_heading    <= i_cmd.heading;
            r_last       <= (cur_phase == lfs_pkg::PH_REST);
        end
    end

    assign o_phase.valid       = r_valid;
    assign o_phase.left_duty   = r_left_duty;
    assign o_phase.right_duty  = r_right_duty;
    assign o_phase.hold_ms     = r_hold;
    assign o_phase.heading_out = r_heading;
    assign o_phase.last_phase  = r_last;

endmodule
`default_nettype wire

// ----- rtl/line_follower_steering.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// line_follower_steering: sensor-driven motor phase sequencer
// Usage:
//   i_sample carries one set of right/center/left samples and a long-run flag.
//   Each accepted item is judged against the previous set and becomes one
//   move, delivered on o_phase as 3 items (kick, run, rest) or 4 when the
//   last heading is repeated (idle pulse first). last_phase marks the rest.
//   i_cfg writes one 8-bit register per item; it is always ready and is
//   meant to be used only while no move is in flight.
// Timing:
//   The first phase of a move passes through the move queue and then the
//   output register; the phase sequencer emits one phase per cycle unless
//   stalled, so the phases of each move set the sustained rate.
//   Samples are accepted every cycle while the two-entry move queue has room.
// Reset:
//   Registers return to their defaults, previous samples to 4, heading to
//   straight, queue and output register empty.
// Stall:
//   A stalled receiver holds the current phase; the queue then fills and
//   i_sample.ready drops until the sequencer moves on.
// ----------------------------------------------------------------------------
module line_follower_steering #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    lfs_sample_if.sink    i_sample,
    lfs_cfg_if.sink       i_cfg,
    lfs_phase_if.source   o_phase
);

    lfs_pkg::t_cfg r_cfg;
    lfs_pkg::t_cmd push_cmd, head_cmd;
    logic          q_push, q_pop, q_full, q_empty;

    assign i_cfg.ready = 1'b1;

    // Register file writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_duty     <= lfs_pkg::RST_FAST_DUTY;
            r_cfg.mid_duty      <= lfs_pkg::RST_MID_DUTY;
            r_cfg.slow_duty     <= lfs_pkg::RST_SLOW_DUTY;
            r_cfg.idle_duty     <= lfs_pkg::RST_IDLE_DUTY;
            r_cfg.kick_ms       <= lfs_pkg::RST_KICK_MS;
            r_cfg.run_ms        <= lfs_pkg::RST_RUN_MS;
            r_cfg.turn_extra_ms <= lfs_pkg::RST_TURN_EXTRA_MS;
            r_cfg.rest_ms       <= lfs_pkg::RST_REST_MS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                lfs_pkg::CFG_FAST_DUTY:     r_cfg.fast_duty     <= i_cfg.data;
                lfs_pkg::CFG_MID_DUTY:      r_cfg.mid_duty      <= i_cfg.data;
                lfs_pkg::CFG_SLOW_DUTY:     r_cfg.slow_duty     <= i_cfg.data;
                lfs_pkg::CFG_IDLE_DUTY:     r_cfg.idle_duty     <= i_cfg.data;
                lfs_pkg::CFG_KICK_MS:       r_cfg.kick_ms       <= i_cfg.data;
                lfs_pkg::CFG_RUN_MS:        r_cfg.run_ms        <= i_cfg.data;
                lfs_pkg::CFG_TURN_EXTRA_MS: r_cfg.turn_extra_ms <= i_cfg.data;
                lfs_pkg::CFG_REST_MS:       r_cfg.rest_ms       <= i_cfg.data;
                default:                    r_cfg               <= r_cfg;
            endcase
        end
    end

    // Decide moves
    lfs_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (i_sample),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (push_cmd)
    );

    // Buffer decided moves
    lfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Sequence motor phases
    lfs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cmd     (head_cmd),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_phase   (o_phase)
    );

`ifndef SYNTHESIS
    // Output register comes up empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_phase.valid)
        else $error("output valid right after reset");

    // A move is only retired from a non-empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("move popped from empty queue");

    // All phases of one move carry the same heading
    a_heading_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_phase.valid && o_phase.ready && !o_phase.last_phase) ##1 o_phase.valid
        |-> o_phase.heading_out == $past(o_phase.heading_out))
        else $error("heading changed inside a move");
`endif

endmodule
`default_nettype wire

// ----- bench/line_follower_steering_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_follower_steering_tb: self-checking bench for the steering sequencer
// Drives sensor sample sets and register writes through the valid/ready
// channels and predicts every motor phase of each move from a shadow copy of
// the registers, previous samples and heading. Phase items are compared field
// by field in order. The stimulus is a short table of hand-picked sample sets,
// then random sets under several register settings and handshake idle mixes,
// a long receiver hold-off and a mid-run drain.
// ----------------------------------------------------------------------------
module line_follower_steering_tb;

    localparam int SAMPLE_BITS    = 10;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 42;
    localparam int NUM_PHASES     = 6;

    // One motor phase as it leaves the block
    typedef struct packed {
        logic [lfs_pkg::DUTY_W-1:0] left_duty;
        logic [lfs_pkg::DUTY_W-1:0] right_duty;
        logic [lfs_pkg::HOLD_W-1:0] hold_ms;
        logic [1:0]                 heading;
        logic                       last_phase;
    } t_motor_step;

    // Steering decision for one sample set
    typedef struct packed {
        lfs_pkg::t_move    mv;
        lfs_pkg::t_heading hd;
        logic              keep;
    } t_steer;

    // One sample set, with an optional hand-written decision
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] right;
        logic [SAMPLE_BITS-1:0] center;
        logic [SAMPLE_BITS-1:0] left;
        logic                   long_run;
        logic                   typed;
        t_steer                 steer;
    } t_sample_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lfs_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    lfs_cfg_if   cfg_if ();
    lfs_phase_if phase_if ();

    line_follower_steering #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (smp_if),
        .i_cfg    (cfg_if),
        .o_phase  (phase_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow state of the steering logic
    logic [SAMPLE_BITS-1:0] prev_right  = SAMPLE_BITS'(lfs_pkg::PREV_RESET);
    logic [SAMPLE_BITS-1:0] prev_center = SAMPLE_BITS'(lfs_pkg::PREV_RESET);
    logic [SAMPLE_BITS-1:0] prev_left   = SAMPLE_BITS'(lfs_pkg::PREV_RESET);
    lfs_pkg::t_heading      last_heading = lfs_pkg::HD_STRAIGHT;
    lfs_pkg::t_cfg reg_shadow = '{
        lfs_pkg::RST_FAST_DUTY, lfs_pkg::RST_MID_DUTY,
        lfs_pkg::RST_SLOW_DUTY, lfs_pkg::RST_IDLE_DUTY,
        lfs_pkg::RST_KICK_MS, lfs_pkg::RST_RUN_MS,
        lfs_pkg::RST_TURN_EXTRA_MS, lfs_pkg::RST_REST_MS
    };

    t_motor_step motor_q[$];
    t_sample_row offered_q[$];

    int errors    = 0;
    int cycle_cnt = 0;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_seq  = 0;

    // Hand-picked sets; decisions typed in where they follow at a glance
    t_sample_row steer_table [15] = '{
        // all zero right after reset: nothing changes, repeat straight slowly
        '{10'd0,    10'd0,    10'd0,    1'b0, 1'b1,
          '{lfs_pkg::MV_SLOW,  lfs_pkg::HD_STRAIGHT, 1'b1}},
        '{10'd1023, 10'd0,    10'd1023, 1'b1, 1'b1,
          '{lfs_pkg::MV_MID,   lfs_pkg::HD_STRAIGHT, 1'b0}},
        '{10'd0,    10'd0,    10'd1023, 1'b0, 1'b1,
          '{lfs_pkg::MV_RIGHT, lfs_pkg::HD_RIGHT,    1'b0}},
        '{10'd1023, 10'd0,    10'd0,    1'b1, 1'b1,
          '{lfs_pkg::MV_LEFT,  lfs_pkg::HD_LEFT,     1'b0}},
        '{10'd1023, 10'd1023, 10'd0,    1'b0, 1'b1,
          '{lfs_pkg::MV_LEFT,  lfs_pkg::HD_LEFT,     1'b0}},
        '{10'd0,    10'd1023, 10'd1023, 1'b1, 1'b1,
          '{lfs_pkg::MV_RIGHT, lfs_pkg::HD_RIGHT,    1'b0}},
        // all full scale: repeat the right heading
        '{10'd1023, 10'd1023, 10'd1023, 1'b0, 1'b1,
          '{lfs_pkg::MV_RIGHT, lfs_pkg::HD_RIGHT,    1'b1}},
        // equal sides below center, right dropped since last set
        '{10'd100,  10'd500,  10'd100,  1'b1, 1'b0,
          '{lfs_pkg::MV_MID,   lfs_pkg::HD_STRAIGHT, 1'b0}},
        '{10'd0,    10'd1023, 10'd900,  1'b0, 1'b0,
          '{lfs_pkg::MV_MID,   lfs_pkg::HD_STRAIGHT, 1'b0}},
        // equal sides below center, left dropped since last set
        '{10'd500,  10'd800,  10'd500,  1'b1, 1'b0,
          '{lfs_pkg::MV_MID,   lfs_pkg::HD_STRAIGHT, 1'b0}},
        '{10'd500,  10'd800,  10'd500,  1'b0, 1'b1,
          '{lfs_pkg::MV_LEFT,  lfs_pkg::HD_LEFT,     1'b1}},
        '{10'd1023, 10'd0,    10'd1023, 1'b0, 1'b1,
          '{lfs_pkg::MV_MID,   lfs_pkg::HD_STRAIGHT, 1'b0}},
        '{10'd1023, 10'd1023, 10'd1023, 1'b1, 1'b1,
          '{lfs_pkg::MV_SLOW,  lfs_pkg::HD_STRAIGHT, 1'b1}},
        '{10'd682,  10'd341,  10'd682,  1'b1, 1'b0,
          '{lfs_pkg::MV_MID,   lfs_pkg::HD_STRAIGHT, 1'b0}},
        '{10'd341,  10'd682,  10'd341,  1'b0, 1'b0,
          '{lfs_pkg::MV_MID,   lfs_pkg::HD_STRAIGHT, 1'b0}}
    };

    // Pick the move from current and previous samples, in priority order
    function automatic t_steer judge_move(input logic [SAMPLE_BITS-1:0] r, c, l);
        t_steer d;
        d.keep = 1'b0;
        d.mv   = lfs_pkg::MV_MID;
        d.hd   = lfs_pkg::HD_STRAIGHT;
        if (l > c && r > c) begin
            d.mv = lfs_pkg::MV_MID;   d.hd = lfs_pkg::HD_STRAIGHT;
        end else if (l > c && l > r) begin
            d.mv = lfs_pkg::MV_RIGHT; d.hd = lfs_pkg::HD_RIGHT;
        end else if (r > c && r > l) begin
            d.mv = lfs_pkg::MV_LEFT;  d.hd = lfs_pkg::HD_LEFT;
        end else if (l < c && l < r) begin
            d.mv = lfs_pkg::MV_LEFT;  d.hd = lfs_pkg::HD_LEFT;
        end else if (r < c && r < l) begin
            d.mv = lfs_pkg::MV_RIGHT; d.hd = lfs_pkg::HD_RIGHT;
        end else if (r < prev_right && r < l) begin
            d.mv = lfs_pkg::MV_RIGHT; d.hd = lfs_pkg::HD_RIGHT;
        end else if (l < prev_left && l < r) begin
            d.mv = lfs_pkg::MV_LEFT;  d.hd = lfs_pkg::HD_LEFT;
        end else if (c > prev_center && l > r) begin
            d.mv = lfs_pkg::MV_RIGHT; d.hd = lfs_pkg::HD_RIGHT;
        end else if (c > prev_center && r > l) begin
            d.mv = lfs_pkg::MV_LEFT;  d.hd = lfs_pkg::HD_LEFT;
        end else if (r < prev_right && r < c) begin
            d.mv = lfs_pkg::MV_RIGHT; d.hd = lfs_pkg::HD_RIGHT;
        end else if (l < prev_left && l < c) begin
            d.mv = lfs_pkg::MV_LEFT;  d.hd = lfs_pkg::HD_LEFT;
        end else if (c < prev_center && c < l) begin
            d.mv = lfs_pkg::MV_SLOW;  d.hd = lfs_pkg::HD_STRAIGHT;
        end else if (c < prev_center && c < r) begin
            d.mv = lfs_pkg::MV_SLOW;  d.hd = lfs_pkg::HD_STRAIGHT;
        end else begin
            // nothing moved: keep heading, straight becomes a slow run
            d.keep = 1'b1;
            d.hd   = last_heading;
            if (last_heading == lfs_pkg::HD_STRAIGHT) begin
                d.mv = lfs_pkg::MV_SLOW;
            end else if (last_heading == lfs_pkg::HD_RIGHT) begin
                d.mv = lfs_pkg::MV_RIGHT;
            end else begin
                d.mv = lfs_pkg::MV_LEFT;
            end
        end
        return d;
    endfunction

    // Queue one expected phase, clamping the hold time
    function automatic void push_step(input logic [lfs_pkg::DUTY_W-1:0] ld, rd,
                                      input int hold,
                                      input lfs_pkg::t_heading hd, input logic last_ph);
        if (hold > int'(lfs_pkg::HOLD_MAX)) begin
            hold = int'(lfs_pkg::HOLD_MAX);
        end
        motor_q.push_back('{ld, rd, lfs_pkg::HOLD_W'(hold), hd, last_ph});
    endfunction

    // Predict the phases of every accepted sample set
    always @(posedge i_clk) begin : sample_accept
        t_sample_row                tag;
        t_steer                     d;
        int                         run_hold;
        logic [lfs_pkg::DUTY_W-1:0] ld;
        logic [lfs_pkg::DUTY_W-1:0] rd;
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            tag = offered_q.pop_front();
            d   = judge_move(smp_if.right_level, smp_if.center_level, smp_if.left_level);
            if (tag.typed) begin
                d = tag.steer;
            end
            if (d.keep) begin
                push_step(reg_shadow.idle_duty, reg_shadow.idle_duty,
                          int'(lfs_pkg::IDLE_PULSE_MS), d.hd, 1'b0);
            end
            // full-power kick
            push_step((d.mv == lfs_pkg::MV_LEFT) ? lfs_pkg::ZERO_DUTY : lfs_pkg::FULL_DUTY,
                      (d.mv == lfs_pkg::MV_RIGHT) ? lfs_pkg::ZERO_DUTY : lfs_pkg::FULL_DUTY,
                      int'(reg_shadow.kick_ms), d.hd, 1'b0);
            // run phase
            run_hold = smp_if.long_run ? 2 * int'(reg_shadow.run_ms) : int'(reg_shadow.run_ms);
            case (d.mv)
                lfs_pkg::MV_MID: begin
                    ld = reg_shadow.mid_duty;  rd = reg_shadow.mid_duty;
                end
                lfs_pkg::MV_SLOW: begin
                    ld = reg_shadow.slow_duty; rd = reg_shadow.slow_duty;
                end
                lfs_pkg::MV_RIGHT: begin
                    ld = reg_shadow.fast_duty; rd = lfs_pkg::ZERO_DUTY;
                    run_hold += int'(reg_shadow.turn_extra_ms);
                end
                default: begin
                    ld = lfs_pkg::ZERO_DUTY;   rd = reg_shadow.fast_duty;
                    run_hold += int'(reg_shadow.turn_extra_ms);
                end
            endcase
            push_step(ld, rd, run_hold, d.hd, 1'b0);
            // stopped rest ends the move
            push_step(lfs_pkg::ZERO_DUTY, lfs_pkg::ZERO_DUTY, int'(reg_shadow.rest_ms),
                      d.hd, 1'b1);
            prev_right   = smp_if.right_level;
            prev_center  = smp_if.center_level;
            prev_left    = smp_if.left_level;
            last_heading = d.hd;
        end
    end

    // Track register writes
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            case (cfg_if.index)
                lfs_pkg::CFG_FAST_DUTY:     reg_shadow.fast_duty     = cfg_if.data;
                lfs_pkg::CFG_MID_DUTY:      reg_shadow.mid_duty      = cfg_if.data;
                lfs_pkg::CFG_SLOW_DUTY:     reg_shadow.slow_duty     = cfg_if.data;
                lfs_pkg::CFG_IDLE_DUTY:     reg_shadow.idle_duty     = cfg_if.data;
                lfs_pkg::CFG_KICK_MS:       reg_shadow.kick_ms       = cfg_if.data;
                lfs_pkg::CFG_RUN_MS:        reg_shadow.run_ms        = cfg_if.data;
                lfs_pkg::CFG_TURN_EXTRA_MS: reg_shadow.turn_extra_ms = cfg_if.data;
                lfs_pkg::CFG_REST_MS:       reg_shadow.rest_ms       = cfg_if.data;
                default: ;
            endcase
        end
    end

    // Compare each phase item with the oldest prediction
    always @(posedge i_clk) begin : phase_check
        t_motor_step want;
        if (i_rst_n && phase_if.valid && phase_if.ready) begin
            if (motor_q.size() == 0) begin
                errors++;
                $display("%0t: phase item with nothing expected: ld %0d rd %0d hold %0d",
                         $time, phase_if.left_duty, phase_if.right_duty, phase_if.hold_ms);
            end else begin
                want = motor_q.pop_front();
                if (phase_if.left_duty !== want.left_duty) begin
                    errors++;
                    $display("%0t: left_duty expected %0d got %0d",
                             $time, want.left_duty, phase_if.left_duty);
                end
                if (phase_if.right_duty !== want.right_duty) begin
                    errors++;
                    $display("%0t: right_duty expected %0d got %0d",
                             $time, want.right_duty, phase_if.right_duty);
                end
                if (phase_if.hold_ms !== want.hold_ms) begin
                    errors++;
                    $display("%0t: hold_ms expected %0d got %0d",
                             $time, want.hold_ms, phase_if.hold_ms);
                end
                if (phase_if.heading_out !== want.heading) begin
                    errors++;
                    $display("%0t: heading_out expected %0d got %0d",
                             $time, want.heading, phase_if.heading_out);
                end
                if (phase_if.last_phase !== want.last_phase) begin
                    errors++;
                    $display("%0t: last_phase expected %0d got %0d",
                             $time, want.last_phase, phase_if.last_phase);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial begin : receiver
        int hold_ack;
        int hold_left;
        hold_ack  = 0;
        hold_left = 0;
        phase_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                phase_if.ready <= 1'b0;
            end else if (hold_seq != hold_ack) begin
                hold_ack  = hold_seq;
                hold_left = HOLDOFF_CYCLES - 1;
                phase_if.ready <= 1'b0;
            end else begin
                phase_if.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("line_follower_steering verification failed");
        $finish;
    end

    // Offer one sample set after a random gap; return at its accepting edge
    task automatic offer_sample(input t_sample_row row);
        while ($urandom_range(99) < idle_pct) begin
            smp_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        offered_q.push_back(row);
        smp_if.valid        <= 1'b1;
        smp_if.right_level  <= row.right;
        smp_if.center_level <= row.center;
        smp_if.left_level   <= row.left;
        smp_if.long_run     <= row.long_run;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    // Drop valid and wait for every predicted phase to come out
    task automatic wait_idle();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (motor_q.size() != 0 || offered_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all eight registers back to back
    task automatic load_regs(input lfs_pkg::t_cfg regs);
        logic [lfs_pkg::CFG_IDX_W-1:0] idx;
        logic [lfs_pkg::DUTY_W-1:0]    val;
        for (int i = 0; i < 8; i++) begin
            idx = lfs_pkg::CFG_IDX_W'(i);
            case (idx)
                lfs_pkg::CFG_FAST_DUTY:     val = regs.fast_duty;
                lfs_pkg::CFG_MID_DUTY:      val = regs.mid_duty;
                lfs_pkg::CFG_SLOW_DUTY:     val = regs.slow_duty;
                lfs_pkg::CFG_IDLE_DUTY:     val = regs.idle_duty;
                lfs_pkg::CFG_KICK_MS:       val = regs.kick_ms;
                lfs_pkg::CFG_RUN_MS:        val = regs.run_ms;
                lfs_pkg::CFG_TURN_EXTRA_MS: val = regs.turn_extra_ms;
                default:                    val = regs.rest_ms;
            endcase
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= val;
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        t_sample_row   row;
        t_sample_row   last_row;
        lfs_pkg::t_cfg regs;
        int            shape;
        i_rst_n             <= 1'b0;
        smp_if.valid        <= 1'b0;
        smp_if.right_level  <= '0;
        smp_if.center_level <= '0;
        smp_if.left_level   <= '0;
        smp_if.long_run     <= 1'b0;
        cfg_if.valid        <= 1'b0;
        cfg_if.index        <= lfs_pkg::CFG_FAST_DUTY;
        cfg_if.data         <= '0;
        last_row = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hand-picked sets under reset registers
        foreach (steer_table[i]) begin
            offer_sample(steer_table[i]);
            last_row = steer_table[i];
        end
        wait_idle();

        // random sets under several register settings and idle mixes
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       regs = '1;
                1:       regs = '0;
                default: regs = lfs_pkg::t_cfg'({$urandom(), $urandom()});
            endcase
            load_regs(regs);
            case (p)
                1: begin
                    idle_pct = 74; stall_pct <= 0;
                end
                2: begin
                    idle_pct = 0;  stall_pct <= 74;
                end
                3, 5: begin
                    idle_pct = 17; stall_pct <= 17;
                end
                default: begin
                    idle_pct = 0;  stall_pct <= 0;
                end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 4) begin
                hold_seq <= hold_seq + 1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == NUM_PHASES - 1 && n == PHASE_ITEMS / 2) begin
                    wait_idle();
                end
                shape = $urandom_range(99);
                row   = '0;
                if (shape < 35) begin
                    // tiny levels: lots of ties between sensors
                    row.right  = SAMPLE_BITS'($urandom_range(7));
                    row.center = SAMPLE_BITS'($urandom_range(7));
                    row.left   = SAMPLE_BITS'($urandom_range(7));
                end else if (shape < 55) begin
                    // matched sides reach the comparisons against the last set
                    row.right  = SAMPLE_BITS'($urandom_range(1023));
                    row.left   = row.right;
                    row.center = SAMPLE_BITS'($urandom_range(1023));
                end else if (shape < 70) begin
                    // repeat the last set to hold the heading
                    row.right  = last_row.right;
                    row.center = last_row.center;
                    row.left   = last_row.left;
                end else begin
                    row.right  = SAMPLE_BITS'($urandom_range(1023));
                    row.center = SAMPLE_BITS'($urandom_range(1023));
                    row.left   = SAMPLE_BITS'($urandom_range(1023));
                end
                row.long_run = 1'($urandom_range(1));
                offer_sample(row);
                last_row = row;
            end
            wait_idle();
        end

        if (errors == 0 && motor_q.size() == 0) begin
            $display("line_follower_steering verification clean");
        end else begin
            $display("line_follower_steering verification failed");
        end
        $finish;
    end

endmodule
